>>> src/rlbb_pkg.sv
// ----------------------------------------------------------------------------
// rlbb_pkg
// Shared constants and types for the row lookahead box blur.
// ----------------------------------------------------------------------------
package rlbb_pkg;
	localparam int WINDOW_DEF      = 50;
	localparam int SAMPLE_BITS_DEF = 8;
	localparam int LANE_BITS       = 8;

	typedef struct packed {
		logic [LANE_BITS-1:0] r;
		logic [LANE_BITS-1:0] g;
		logic [LANE_BITS-1:0] b;
	} pix_t;
endpackage

>>> src/rlbb_if.sv
// ----------------------------------------------------------------------------
// rlbb_in_if / rlbb_out_if
// Valid/ready channels for input pixels and blurred results.
// ----------------------------------------------------------------------------
interface rlbb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic       row_end;
	modport source (output valid, red_in, green_in, blue_in, row_end, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, row_end, output ready);
endinterface

interface rlbb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       row_last;
	logic       run_last;
	modport source (output valid, red_out, green_out, blue_out, row_last, run_last,
		input ready);
	modport sink   (input valid, red_out, green_out, blue_out, row_last, run_last,
		output ready);
endinterface

>>> src/rlbb_cell.sv
// ----------------------------------------------------------------------------
// rlbb_cell
// One slot of the pixel chain: holds a pixel, shifts it toward the head.
// ----------------------------------------------------------------------------
module rlbb_cell (
	input  logic           clk,
	input  logic           ld,
	input  logic           shift,
	input  rlbb_pkg::pix_t ld_pix,
	input  rlbb_pkg::pix_t nxt_pix,
	output rlbb_pkg::pix_t pix
);
	rlbb_pkg::pix_t pix_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			pix_q <= ld ? ld_pix : nxt_pix;
		end else if (ld) begin
			pix_q <= ld_pix;
		end
	end

	assign pix = pix_q;
endmodule

>>> src/rlbb_div.sv
// ----------------------------------------------------------------------------
// rlbb_div
// Restoring divider: one quotient bit a cycle, sample by a variable divisor.
// ----------------------------------------------------------------------------
module rlbb_div #(
	parameter int SB = rlbb_pkg::SAMPLE_BITS_DEF,
	parameter int DB = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [SB-1:0] num,
	input  logic [DB-1:0] den,
	output logic          done,
	output logic [SB-1:0] quo
);
	localparam int CB = $clog2(SB + 1);

	logic [SB-1:0] n_q;
	logic [SB-1:0] q_q;
	logic [DB:0]   rem_q;
	logic [DB-1:0] d_q;
	logic [CB-1:0] cnt_q;
	logic          busy_q;
	logic [DB:0]   trial;

	assign trial = {rem_q[DB-1:0], n_q[SB-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CB'(SB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CB'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (trial >= {1'b0, d_q}) begin
				rem_q <= trial - {1'b0, d_q};
				q_q   <= SB'({q_q, 1'b1});
			end else begin
				rem_q <= trial;
				q_q   <= SB'({q_q, 1'b0});
			end
		end
	end

	assign done = busy_q && cnt_q == CB'(1);
	assign quo  = (trial >= {1'b0, d_q}) ? SB'({q_q, 1'b1}) : SB'({q_q, 1'b0});
endmodule

>>> src/row_lookahead_box_blur.sv
// ----------------------------------------------------------------------------
// row_lookahead_box_blur
// Forward-looking horizontal box blur over a row-ordered RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   px (sink) takes one pixel a beat with a row_end flag; res (source) gives
//   blurred pixels oldest first. A pixel is stored in a chain of WINDOW cells;
//   the head of the chain is the oldest pending pixel. Once WINDOW pixels of a
//   row are pending the oldest is blurred; a row end flushes the whole chain.
//   Pixels that complete no result are taken back to back.
//   Each result sums N-1 neighbor terms; each term is one of three divisions
//   by 2N through one shared bit-serial divider. Each result is started by a
//   beat or by the previous flush result. Pixels are taken only while no
//   result is being computed. Results wait in an output register; a stalled
//   receiver holds it, and the block stops once the next result is ready.
//   Reset empties the chain and the output register; cells need no clearing.
// ----------------------------------------------------------------------------
module row_lookahead_box_blur #(
	parameter int WINDOW      = rlbb_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = rlbb_pkg::SAMPLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rlbb_in_if.sink    px,
	rlbb_out_if.source res
);
	localparam int IB = $clog2(WINDOW + 1);
	localparam int DB = IB + 1;
	localparam int SB = SAMPLE_BITS;
	localparam int AB = SB + 1;

	typedef enum logic [2:0] {ST_IDLE, ST_SELF, ST_DIV, ST_WAIT, ST_NEXT, ST_OUT}
		state_t;

	state_t         state_q;
	logic [IB-1:0]  cnt_q;
	logic [IB-1:0]  nb_q;
	logic [IB-1:0]  n_q;
	logic [1:0]     ch_q;
	logic           flush_q;
	logic [AB-1:0]  acc_q [3];

	logic                          ov_q;
	logic [rlbb_pkg::LANE_BITS-1:0] red_q;
	logic [rlbb_pkg::LANE_BITS-1:0] green_q;
	logic [rlbb_pkg::LANE_BITS-1:0] blue_q;
	logic                          row_last_q;
	logic                          run_last_q;
	logic                          row_fin;
	logic                          run_fin;

	rlbb_pkg::pix_t pix [WINDOW];
	rlbb_pkg::pix_t ld_pix;
	logic           shift;
	logic           out_ld;

	assign ld_pix.r = rlbb_pkg::LANE_BITS'(px.red_in[SB-1:0]);
	assign ld_pix.g = rlbb_pkg::LANE_BITS'(px.green_in[SB-1:0]);
	assign ld_pix.b = rlbb_pkg::LANE_BITS'(px.blue_in[SB-1:0]);

	logic acc_in;
	assign px.ready = state_q == ST_IDLE;
	assign acc_in   = px.valid && px.ready;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_cell
			rlbb_cell u_cell (
				.clk     (clk),
				.ld      (acc_in && cnt_q == IB'(gi)),
				.shift   (shift),
				.ld_pix  (ld_pix),
				.nxt_pix ((gi == WINDOW - 1) ? pix[gi] : pix[(gi + 1) % WINDOW]),
				.pix     (pix[gi])
			);
		end
	endgenerate

	rlbb_pkg::pix_t nb_pix;
	logic [SB-1:0]  div_num;
	logic           div_start;
	logic           div_done;
	logic [SB-1:0]  div_quo;

	assign nb_pix = pix[nb_q[$clog2(WINDOW)-1:0]];

	always_comb begin
		case (ch_q)
			2'd0:    div_num = nb_pix.r[SB-1:0];
			2'd1:    div_num = nb_pix.g[SB-1:0];
			default: div_num = nb_pix.b[SB-1:0];
		endcase
	end

	assign div_start = state_q == ST_DIV;

	rlbb_div #(.SB(SB), .DB(DB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    ({n_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign row_fin = flush_q && cnt_q == IB'(1);
	assign run_fin = !flush_q || cnt_q == IB'(1);
	assign out_ld  = state_q == ST_OUT && (!ov_q || res.ready);
	assign shift   = out_ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						flush_q <= px.row_end;
						if (px.row_end) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_SELF;
						end else if (cnt_q == IB'(WINDOW - 1)) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_SELF;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_SELF: begin
					state_q <= (n_q == IB'(1)) ? ST_OUT : ST_DIV;
				end
				ST_DIV:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (ch_q == 2'd2 && nb_q == n_q - 1'b1) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_OUT: begin
					if (out_ld) begin
						cnt_q <= cnt_q - 1'b1;
						if (flush_q && cnt_q != IB'(1)) begin
							state_q <= ST_SELF;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SELF: begin
				acc_q[0] <= AB'(pix[0].r[SB-1:0] >> 1);
				acc_q[1] <= AB'(pix[0].g[SB-1:0] >> 1);
				acc_q[2] <= AB'(pix[0].b[SB-1:0] >> 1);
				nb_q     <= IB'(1);
				ch_q     <= 2'd0;
			end
			ST_WAIT: begin
				if (div_done) begin
					acc_q[ch_q] <= acc_q[ch_q] + AB'(div_quo);
				end
			end
			ST_NEXT: begin
				if (ch_q == 2'd2) begin
					ch_q <= 2'd0;
					nb_q <= nb_q + 1'b1;
				end else begin
					ch_q <= ch_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == ST_IDLE) begin
			n_q = '0;
		end else begin
			n_q = (cnt_q < IB'(WINDOW)) ? cnt_q : IB'(WINDOW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_ld) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			red_q      <= rlbb_pkg::LANE_BITS'(acc_q[0]);
			green_q    <= rlbb_pkg::LANE_BITS'(acc_q[1]);
			blue_q     <= rlbb_pkg::LANE_BITS'(acc_q[2]);
			row_last_q <= row_fin;
			run_last_q <= run_fin;
		end
	end

	assign res.valid     = ov_q;
	assign res.red_out   = red_q;
	assign res.green_out = green_q;
	assign res.blue_out  = blue_q;
	assign res.row_last  = row_last_q;
	assign res.run_last  = run_last_q;

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable({res.red_out, res.green_out,
		res.blue_out, res.row_last, res.run_last})) else $error("result dropped on stall");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IB'(WINDOW)) else $error("chain overfull");
	a_row_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.row_last |-> res.run_last) else $error("row_last without run_last");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld && run_fin |=> state_q == ST_IDLE)
		else $error("did not return to idle");
endmodule
